>>> hdl/trac_pkg.sv
package trac_pkg;

  typedef enum logic [1:0] {
    OP_POLL    = 2'd0,
    OP_TOGGLE  = 2'd1,
    OP_SINK    = 2'd2,
    OP_SOURCE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    LINK_UNATTACHED = 3'd0,
    LINK_WAIT_VBUS  = 3'd1,
    LINK_WAIT_START = 3'd2,
    LINK_ACTIVE     = 3'd3,
    LINK_ROLE_WAIT  = 3'd4
  } link_t;

  localparam logic [1:0] ORIENT_NONE = 2'd0;
  localparam logic [1:0] ORIENT_CC1  = 2'd1;
  localparam logic [1:0] ORIENT_CC2  = 2'd2;

  localparam logic [1:0] START_NONE   = 2'd0;
  localparam logic [1:0] START_DEVICE = 2'd1;
  localparam logic [1:0] START_HOST   = 2'd2;

  localparam logic [1:0] TERM_NONE   = 2'd0;
  localparam logic [1:0] TERM_SINK   = 2'd1;
  localparam logic [1:0] TERM_SOURCE = 2'd2;

  localparam logic [2:0] STATUS_NONE    = 3'd0;
  localparam logic [2:0] STATUS_SAME    = 3'd1;
  localparam logic [2:0] STATUS_BLOCKED = 3'd2;
  localparam logic [2:0] STATUS_DONE    = 3'd3;
  localparam logic [2:0] STATUS_ABORTED = 3'd4;
  localparam logic [2:0] STATUS_BUSY    = 3'd5;

  localparam logic [1:0] REG_ATTACH    = 2'd0;
  localparam logic [1:0] REG_DETACH    = 2'd1;
  localparam logic [1:0] REG_START     = 2'd2;
  localparam logic [1:0] REG_DISCHARGE = 2'd3;

  localparam logic [15:0] ATTACH_RESET    = 16'd80;
  localparam logic [15:0] DETACH_RESET    = 16'd120;
  localparam logic [15:0] START_RESET     = 16'd200;
  localparam logic [15:0] DISCHARGE_RESET = 16'd150;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [1:0]  cc1_level;
    logic [1:0]  cc2_level;
    logic        vbus_present;
  } item_t;

  typedef struct packed {
    logic       role_is_source;
    logic [2:0] connection_state;
    logic [1:0] orientation;
    logic       vbus_switch_on;
    logic       usb_running;
    logic [1:0] usb_start_cmd;
    logic       usb_stop_cmd;
    logic [1:0] termination_load;
    logic [2:0] request_status;
  } result_t;

  function automatic logic elapsed(input logic [31:0] now, input logic [31:0] since,
                                   input logic [15:0] limit);
    logic [31:0] diff;
    diff = now - since;
    return diff >= {16'd0, limit};
  endfunction

endpackage

>>> hdl/typec_role_attach_controller_core.sv
// USB Type-C dual-role attach controller. Each transaction on the item channel carries
// a millisecond timestamp, both CC levels, VBUS presence and a role opcode, and yields
// exactly one transaction on the result channel. An item is registered on entry, then
// evaluated against the connection state into the result register, so one item is taken
// per clock while the result side does not stall; a stalled result holds off the item
// channel. Debounce and discharge timers compare wrap-safe timestamp differences against
// the four 16-bit APB registers (attach, detach, USB start delay, discharge wait at byte
// addresses 0, 4, 8, 12).
module typec_role_attach_controller_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  trac_pkg::item_t      item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output trac_pkg::result_t    result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [15:0] attach_debounce_ms;
  logic [15:0] detach_debounce_ms;
  logic [15:0] usb_start_delay_ms;
  logic [15:0] discharge_wait_ms;

  logic            stage_valid;
  trac_pkg::item_t stage;
  logic            advance;

  logic                source_role, source_role_next;
  trac_pkg::link_t     link_state, link_state_next;
  logic [1:0]          saved_link_state, saved_link_state_next;
  logic                pending_role, pending_role_next;
  logic [1:0]          accepted_orientation, accepted_orientation_next;
  logic [1:0]          seen_orientation, seen_orientation_next;
  logic [31:0]         seen_since, seen_since_next;
  logic [31:0]         vbus_seen_at, vbus_seen_at_next;
  logic [31:0]         switch_started_at, switch_started_at_next;
  logic                switch_on, switch_on_next;
  logic                stack_started, stack_started_next;

  logic [1:0] start_pulse;
  logic       stop_pulse;
  logic [1:0] term_pulse;
  logic [2:0] status_out;
  logic       run;
  logic       want;
  logic       take;
  logic       take_to;
  logic [1:0] det;
  logic       gone;

  assign pready     = 1'b1;
  assign advance    = !result_valid || !result_stall;
  assign item_stall = !advance;

  always_comb begin
    unique case (paddr[3:2])
      trac_pkg::REG_ATTACH:    prdata = {16'd0, attach_debounce_ms};
      trac_pkg::REG_DETACH:    prdata = {16'd0, detach_debounce_ms};
      trac_pkg::REG_START:     prdata = {16'd0, usb_start_delay_ms};
      trac_pkg::REG_DISCHARGE: prdata = {16'd0, discharge_wait_ms};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attach_debounce_ms <= trac_pkg::ATTACH_RESET;
      detach_debounce_ms <= trac_pkg::DETACH_RESET;
      usb_start_delay_ms <= trac_pkg::START_RESET;
      discharge_wait_ms  <= trac_pkg::DISCHARGE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        trac_pkg::REG_ATTACH:    attach_debounce_ms <= pwdata[15:0];
        trac_pkg::REG_DETACH:    detach_debounce_ms <= pwdata[15:0];
        trac_pkg::REG_START:     usb_start_delay_ms <= pwdata[15:0];
        trac_pkg::REG_DISCHARGE: discharge_wait_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    source_role_next          = source_role;
    link_state_next           = link_state;
    saved_link_state_next     = saved_link_state;
    pending_role_next         = pending_role;
    accepted_orientation_next = accepted_orientation;
    seen_orientation_next     = seen_orientation;
    seen_since_next           = seen_since;
    vbus_seen_at_next         = vbus_seen_at;
    switch_started_at_next    = switch_started_at;
    switch_on_next            = switch_on;
    stack_started_next        = stack_started;
    start_pulse = trac_pkg::START_NONE;
    stop_pulse  = 1'b0;
    term_pulse  = trac_pkg::TERM_NONE;
    status_out  = trac_pkg::STATUS_NONE;
    run         = 1'b1;
    take        = 1'b0;
    take_to     = 1'b0;
    det         = trac_pkg::ORIENT_NONE;
    gone        = 1'b0;

    unique case (stage.opcode)
      trac_pkg::OP_TOGGLE: want = !source_role;
      trac_pkg::OP_SOURCE: want = 1'b1;
      default:             want = 1'b0;
    endcase

    if (link_state == trac_pkg::LINK_ROLE_WAIT) begin
      run = 1'b0;
      if (stage.opcode != trac_pkg::OP_POLL) status_out = trac_pkg::STATUS_BUSY;
      if (trac_pkg::elapsed(stage.now_ms, switch_started_at, discharge_wait_ms)) begin
        if (stage.vbus_present) begin
          link_state_next = trac_pkg::link_t'({1'b0, saved_link_state});
          status_out      = trac_pkg::STATUS_ABORTED;
        end else begin
          take    = 1'b1;
          take_to = pending_role;
        end
      end
    end else if (stage.opcode != trac_pkg::OP_POLL) begin
      if (want == source_role) begin
        status_out = trac_pkg::STATUS_SAME;
      end else if (want) begin
        if (stage.vbus_present) begin
          status_out = trac_pkg::STATUS_BLOCKED;
        end else begin
          pending_role_next = 1'b1;
          take    = 1'b1;
          take_to = 1'b1;
          run     = 1'b0;
        end
      end else begin
        switch_on_next         = 1'b0;
        saved_link_state_next  = link_state[1:0];
        pending_role_next      = 1'b0;
        switch_started_at_next = stage.now_ms;
        link_state_next        = trac_pkg::LINK_ROLE_WAIT;
        run                    = 1'b0;
      end
    end

    if (take) begin
      stop_pulse                = 1'b1;
      source_role_next          = take_to;
      switch_on_next            = 1'b0;
      seen_orientation_next     = trac_pkg::ORIENT_NONE;
      seen_since_next           = stage.now_ms;
      accepted_orientation_next = trac_pkg::ORIENT_NONE;
      link_state_next           = trac_pkg::LINK_UNATTACHED;
      vbus_seen_at_next         = 32'd0;
      stack_started_next        = 1'b0;
      term_pulse  = take_to ? trac_pkg::TERM_SOURCE : trac_pkg::TERM_SINK;
      status_out  = trac_pkg::STATUS_DONE;
    end

    if (run) begin
      if (source_role) begin
        if (stage.cc1_level == 2'd1 && stage.cc2_level != 2'd1) begin
          det = trac_pkg::ORIENT_CC1;
        end else if (stage.cc2_level == 2'd1 && stage.cc1_level != 2'd1) begin
          det = trac_pkg::ORIENT_CC2;
        end
      end else begin
        if (stage.cc1_level != 2'd0 && stage.cc2_level == 2'd0) begin
          det = trac_pkg::ORIENT_CC1;
        end else if (stage.cc2_level != 2'd0 && stage.cc1_level == 2'd0) begin
          det = trac_pkg::ORIENT_CC2;
        end
      end
      if (det != seen_orientation) begin
        seen_orientation_next = det;
        seen_since_next       = stage.now_ms;
      end
      gone = trac_pkg::elapsed(stage.now_ms, seen_since_next, detach_debounce_ms);

      unique case (link_state)
        trac_pkg::LINK_UNATTACHED: begin
          if (seen_orientation_next != trac_pkg::ORIENT_NONE &&
              trac_pkg::elapsed(stage.now_ms, seen_since_next, attach_debounce_ms)) begin
            accepted_orientation_next = seen_orientation_next;
            switch_on_next            = source_role;
            link_state_next           = trac_pkg::LINK_WAIT_VBUS;
          end
        end
        trac_pkg::LINK_WAIT_VBUS, trac_pkg::LINK_WAIT_START: begin
          if (seen_orientation_next == trac_pkg::ORIENT_NONE) begin
            if (gone) begin
              switch_on_next            = 1'b0;
              accepted_orientation_next = trac_pkg::ORIENT_NONE;
              link_state_next           = trac_pkg::LINK_UNATTACHED;
            end
          end else if (link_state == trac_pkg::LINK_WAIT_VBUS) begin
            if (stage.vbus_present) begin
              vbus_seen_at_next = stage.now_ms;
              link_state_next   = trac_pkg::LINK_WAIT_START;
            end
          end else if (!stage.vbus_present) begin
            switch_on_next  = 1'b0;
            link_state_next = trac_pkg::LINK_WAIT_VBUS;
          end else if (trac_pkg::elapsed(stage.now_ms, vbus_seen_at,
                                         usb_start_delay_ms)) begin
            if (!stack_started) begin
              start_pulse = source_role ? trac_pkg::START_HOST : trac_pkg::START_DEVICE;
              stack_started_next = 1'b1;
            end
            link_state_next = trac_pkg::LINK_ACTIVE;
          end
        end
        trac_pkg::LINK_ACTIVE: begin
          if ((seen_orientation_next == trac_pkg::ORIENT_NONE || !stage.vbus_present) &&
              gone) begin
            accepted_orientation_next = trac_pkg::ORIENT_NONE;
            link_state_next           = trac_pkg::LINK_UNATTACHED;
            if (source_role) begin
              switch_on_next        = 1'b0;
              stop_pulse            = 1'b1;
              stack_started_next    = 1'b0;
              seen_orientation_next = trac_pkg::ORIENT_NONE;
              seen_since_next       = stage.now_ms;
              vbus_seen_at_next     = 32'd0;
              term_pulse            = trac_pkg::TERM_SOURCE;
            end else begin
              stack_started_next = 1'b1;
            end
          end
        end
        default: begin
          switch_on_next            = 1'b0;
          stop_pulse                = 1'b1;
          stack_started_next        = 1'b0;
          accepted_orientation_next = trac_pkg::ORIENT_NONE;
          link_state_next           = trac_pkg::LINK_UNATTACHED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid          <= 1'b0;
      result_valid         <= 1'b0;
      source_role          <= 1'b0;
      link_state           <= trac_pkg::LINK_UNATTACHED;
      saved_link_state     <= 2'd0;
      pending_role         <= 1'b0;
      accepted_orientation <= trac_pkg::ORIENT_NONE;
      seen_orientation     <= trac_pkg::ORIENT_NONE;
      seen_since           <= 32'd0;
      vbus_seen_at         <= 32'd0;
      switch_started_at    <= 32'd0;
      switch_on            <= 1'b0;
      stack_started        <= 1'b0;
    end else begin
      if (advance) begin
        stage_valid  <= item_valid;
        result_valid <= stage_valid;
        if (item_valid) stage <= item;
        if (stage_valid) begin
          source_role          <= source_role_next;
          link_state           <= link_state_next;
          saved_link_state     <= saved_link_state_next;
          pending_role         <= pending_role_next;
          accepted_orientation <= accepted_orientation_next;
          seen_orientation     <= seen_orientation_next;
          seen_since           <= seen_since_next;
          vbus_seen_at         <= vbus_seen_at_next;
          switch_started_at    <= switch_started_at_next;
          switch_on            <= switch_on_next;
          stack_started        <= stack_started_next;
          result.role_is_source   <= source_role_next;
          result.connection_state <= link_state_next;
          result.orientation      <= accepted_orientation_next;
          result.vbus_switch_on   <= switch_on_next;
          result.usb_running      <= stack_started_next;
          result.usb_start_cmd    <= start_pulse;
          result.usb_stop_cmd     <= stop_pulse;
          result.termination_load <= term_pulse;
          result.request_status   <= status_out;
        end
      end
    end
  end

  a_switch_only_source: assert property (@(posedge clk) disable iff (rst)
    switch_on |-> source_role)
    else $error("VBUS switch on while in sink role");

  a_switch_off_in_role_wait: assert property (@(posedge clk) disable iff (rst)
    link_state == trac_pkg::LINK_ROLE_WAIT |-> !switch_on)
    else $error("VBUS switch on during role switch wait");

  a_start_sets_running: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.usb_start_cmd != trac_pkg::START_NONE |-> result.usb_running)
    else $error("start pulse without stack flag");

  a_result_follows_stage: assert property (@(posedge clk) disable iff (rst)
    stage_valid && advance |=> result_valid)
    else $error("evaluated item produced no result");

endmodule

>>> test/typec_role_attach_controller_core_tb.sv
`timescale 1ns / 1ps

module typec_role_attach_controller_core_tb;

  localparam int CYCLE_LIMIT = 600000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  trac_pkg::item_t   item_bus = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  trac_pkg::result_t result_bus;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // shadow of the controller
  logic        role_src, pend_role, sw_on, stack_on;
  logic [2:0]  link;
  logic [1:0]  saved_link, acc_orient, seen_orient;
  logic [31:0] seen_at, vbus_at, switch_at;
  logic [15:0] attach_ms, detach_ms, start_ms, discharge_ms;
  trac_pkg::result_t item_flags;

  trac_pkg::result_t predicted_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;
  int          rx_hold = 0;
  logic [31:0] now_cursor = '0;

  typec_role_attach_controller_core DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item_bus),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void reset_shadow();
    role_src = 1'b0;
    pend_role = 1'b0;
    sw_on = 1'b0;
    stack_on = 1'b0;
    link = trac_pkg::LINK_UNATTACHED;
    saved_link = '0;
    acc_orient = trac_pkg::ORIENT_NONE;
    seen_orient = trac_pkg::ORIENT_NONE;
    seen_at = '0;
    vbus_at = '0;
    switch_at = '0;
    attach_ms = trac_pkg::ATTACH_RESET;
    detach_ms = trac_pkg::DETACH_RESET;
    start_ms = trac_pkg::START_RESET;
    discharge_ms = trac_pkg::DISCHARGE_RESET;
  endfunction

  // wrap-safe age check
  function automatic logic aged(logic [31:0] now, logic [31:0] since, logic [15:0] lim);
    logic [31:0] diff;
    diff = now - since;
    return diff >= {16'd0, lim};
  endfunction

  function automatic logic [1:0] sense_cc(logic [1:0] c1, logic [1:0] c2);
    if (role_src) begin
      if (c1 == 2'd1 && c2 != 2'd1) return trac_pkg::ORIENT_CC1;
      if (c2 == 2'd1 && c1 != 2'd1) return trac_pkg::ORIENT_CC2;
    end else begin
      if (c1 != 2'd0 && c2 == 2'd0) return trac_pkg::ORIENT_CC1;
      if (c2 != 2'd0 && c1 == 2'd0) return trac_pkg::ORIENT_CC2;
    end
    return trac_pkg::ORIENT_NONE;
  endfunction

  function automatic void enter_role(logic r, logic [31:0] now);
    item_flags.usb_stop_cmd = 1'b1;
    role_src = r;
    sw_on = 1'b0;
    seen_orient = trac_pkg::ORIENT_NONE;
    seen_at = now;
    acc_orient = trac_pkg::ORIENT_NONE;
    link = trac_pkg::LINK_UNATTACHED;
    vbus_at = '0;
    stack_on = 1'b0;
    item_flags.termination_load = r ? trac_pkg::TERM_SOURCE : trac_pkg::TERM_SINK;
    item_flags.request_status = trac_pkg::STATUS_DONE;
  endfunction

  function automatic void track_link(trac_pkg::item_t it);
    logic [1:0] det;
    det = sense_cc(it.cc1_level, it.cc2_level);
    if (det != seen_orient) begin
      seen_orient = det;
      seen_at = it.now_ms;
    end
    case (link)
      trac_pkg::LINK_UNATTACHED: begin
        if (seen_orient != trac_pkg::ORIENT_NONE && aged(it.now_ms, seen_at, attach_ms)) begin
          acc_orient = seen_orient;
          sw_on = role_src;
          link = trac_pkg::LINK_WAIT_VBUS;
        end
      end
      trac_pkg::LINK_WAIT_VBUS, trac_pkg::LINK_WAIT_START: begin
        if (seen_orient == trac_pkg::ORIENT_NONE) begin
          if (aged(it.now_ms, seen_at, detach_ms)) begin
            sw_on = 1'b0;
            acc_orient = trac_pkg::ORIENT_NONE;
            link = trac_pkg::LINK_UNATTACHED;
          end
        end else if (link == trac_pkg::LINK_WAIT_VBUS) begin
          if (it.vbus_present) begin
            vbus_at = it.now_ms;
            link = trac_pkg::LINK_WAIT_START;
          end
        end else if (!it.vbus_present) begin
          sw_on = 1'b0;
          link = trac_pkg::LINK_WAIT_VBUS;
        end else if (aged(it.now_ms, vbus_at, start_ms)) begin
          if (!stack_on) begin
            item_flags.usb_start_cmd = role_src ? trac_pkg::START_HOST : trac_pkg::START_DEVICE;
            stack_on = 1'b1;
          end
          link = trac_pkg::LINK_ACTIVE;
        end
      end
      trac_pkg::LINK_ACTIVE: begin
        if ((seen_orient == trac_pkg::ORIENT_NONE || !it.vbus_present) &&
            aged(it.now_ms, seen_at, detach_ms)) begin
          if (role_src) begin
            sw_on = 1'b0;
            item_flags.usb_stop_cmd = 1'b1;
            stack_on = 1'b0;
            acc_orient = trac_pkg::ORIENT_NONE;
            seen_orient = trac_pkg::ORIENT_NONE;
            seen_at = it.now_ms;
            vbus_at = '0;
            link = trac_pkg::LINK_UNATTACHED;
            item_flags.termination_load = trac_pkg::TERM_SOURCE;
          end else begin
            // sink keeps the stack running
            stack_on = 1'b1;
            acc_orient = trac_pkg::ORIENT_NONE;
            link = trac_pkg::LINK_UNATTACHED;
          end
        end
      end
      default: begin
        sw_on = 1'b0;
        item_flags.usb_stop_cmd = 1'b1;
        stack_on = 1'b0;
        acc_orient = trac_pkg::ORIENT_NONE;
        link = trac_pkg::LINK_UNATTACHED;
      end
    endcase
  endfunction

  function automatic trac_pkg::result_t advance_controller(trac_pkg::item_t it);
    trac_pkg::result_t r;
    logic    run;
    logic    want;
    item_flags = '0;
    run = 1'b1;
    if (link == trac_pkg::LINK_ROLE_WAIT) begin
      run = 1'b0;
      if (it.opcode != trac_pkg::OP_POLL) item_flags.request_status = trac_pkg::STATUS_BUSY;
      if (aged(it.now_ms, switch_at, discharge_ms)) begin
        if (it.vbus_present) begin
          link = {1'b0, saved_link};
          item_flags.request_status = trac_pkg::STATUS_ABORTED;
        end else begin
          enter_role(pend_role, it.now_ms);
        end
      end
    end else if (it.opcode != trac_pkg::OP_POLL) begin
      want = (it.opcode == trac_pkg::OP_TOGGLE) ? !role_src :
             (it.opcode == trac_pkg::OP_SOURCE);
      if (want == role_src) begin
        item_flags.request_status = trac_pkg::STATUS_SAME;
      end else if (want) begin
        if (it.vbus_present) begin
          item_flags.request_status = trac_pkg::STATUS_BLOCKED;
        end else begin
          pend_role = 1'b1;
          enter_role(1'b1, it.now_ms);
          run = 1'b0;
        end
      end else begin
        sw_on = 1'b0;
        saved_link = link[1:0];
        pend_role = 1'b0;
        switch_at = it.now_ms;
        link = trac_pkg::LINK_ROLE_WAIT;
        run = 1'b0;
      end
    end
    if (run) track_link(it);
    r = item_flags;
    r.role_is_source = role_src;
    r.connection_state = link;
    r.orientation = acc_orient;
    r.vbus_switch_on = sw_on;
    r.usb_running = stack_on;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(trac_pkg::result_t want, trac_pkg::result_t got);
    check_field("role_is_source", 32'(want.role_is_source), 32'(got.role_is_source));
    check_field("connection_state", 32'(want.connection_state),
                32'(got.connection_state));
    check_field("orientation", 32'(want.orientation), 32'(got.orientation));
    check_field("vbus_switch_on", 32'(want.vbus_switch_on), 32'(got.vbus_switch_on));
    check_field("usb_running", 32'(want.usb_running), 32'(got.usb_running));
    check_field("usb_start_cmd", 32'(want.usb_start_cmd), 32'(got.usb_start_cmd));
    check_field("usb_stop_cmd", 32'(want.usb_stop_cmd), 32'(got.usb_stop_cmd));
    check_field("termination_load", 32'(want.termination_load),
                32'(got.termination_load));
    check_field("request_status", 32'(want.request_status), 32'(got.request_status));
  endtask

  // result side: check each transaction, then hold off a random number of cycles
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with none pending, expected nothing, got %h",
                   $time, result_bus);
          mismatches++;
        end else begin
          compare_result(predicted_results.pop_front(), result_bus);
        end
        rx_hold = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (rx_hold > 0) begin
        result_stall <= 1'b1;
        rx_hold--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [31:0] now, logic [1:0] c1,
                           logic [1:0] c2, logic vb);
    int              gap;
    trac_pkg::item_t it;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    it.opcode = op;
    it.now_ms = now;
    it.cc1_level = c1;
    it.cc2_level = c2;
    it.vbus_present = vb;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    predicted_results.push_back(advance_controller(it));
    now_cursor = now;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_access(logic [1:0] idx, logic [15:0] val, bit wr);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (!wr && prdata !== {16'd0, val}) begin
      $display("%0t: register %0d expected %0d, got %0d", $time, idx, val, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_timing(logic [15:0] att, logic [15:0] det, logic [15:0] sta,
                                logic [15:0] dis);
    wait_idle();
    reg_access(trac_pkg::REG_ATTACH, att, 1'b1);
    reg_access(trac_pkg::REG_DETACH, det, 1'b1);
    reg_access(trac_pkg::REG_START, sta, 1'b1);
    reg_access(trac_pkg::REG_DISCHARGE, dis, 1'b1);
    attach_ms = att;
    detach_ms = det;
    start_ms = sta;
    discharge_ms = dis;
    reg_access(trac_pkg::REG_ATTACH, att, 1'b0);
    reg_access(trac_pkg::REG_DETACH, det, 1'b0);
    reg_access(trac_pkg::REG_START, sta, 1'b0);
    reg_access(trac_pkg::REG_DISCHARGE, dis, 1'b0);
  endtask

  // timestamp advance, biased toward the programmed thresholds
  function automatic logic [31:0] next_step();
    logic [15:0] lim;
    case ($urandom_range(0, 3))
      0: lim = attach_ms;
      1: lim = detach_ms;
      2: lim = start_ms;
      default: lim = discharge_ms;
    endcase
    case ($urandom_range(0, 19))
      0, 1: return 32'd0;
      2, 3, 4, 5, 6: return $urandom_range(1, 20);
      7, 8, 9: return $urandom_range(0, 2 * lim + 2);
      10, 11: return 32'(lim);
      12, 13: return (lim == 16'd0) ? 32'd0 : 32'(lim) - 32'd1;
      14, 15, 16: return $urandom_range(0, 300);
      17, 18: return $urandom_range(0, 70000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_delay();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 300));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // attach/detach sessions with random timing, role requests and some noise
  task automatic run_sessions(int count);
    int          sent, len, k;
    bit          use_cc2;
    logic [1:0]  op, c1, c2, hi, lo;
    logic        vb;
    logic [31:0] stamp;
    sent = 0;
    while (sent < count) begin
      idle_on = ($urandom_range(0, 4) != 0);
      len = $urandom_range(8, 40);
      use_cc2 = 1'($urandom_range(0, 1));
      for (k = 0; k < len && sent < count; k++) begin
        stamp = now_cursor + next_step();
        op = trac_pkg::OP_POLL;
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 2))
            0: op = trac_pkg::OP_TOGGLE;
            1: op = trac_pkg::OP_SINK;
            default: op = trac_pkg::OP_SOURCE;
          endcase
        end
        if (k < len * 7 / 10) begin
          if (role_src) begin
            hi = 2'd1;
            lo = 2'($urandom_range(0, 3));
            if (lo == 2'd1) lo = 2'd0;
          end else begin
            hi = 2'($urandom_range(1, 3));
            lo = 2'd0;
          end
          c1 = use_cc2 ? lo : hi;
          c2 = use_cc2 ? hi : lo;
          if (link == trac_pkg::LINK_UNATTACHED) vb = ($urandom_range(0, 9) < 2);
          else vb = ($urandom_range(0, 9) < 8);
        end else begin
          // equal levels never read as attached
          c1 = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : 2'd0;
          c2 = c1;
          vb = ($urandom_range(0, 9) == 0);
        end
        if (link == trac_pkg::LINK_ROLE_WAIT) vb = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0) begin
          op = 2'($urandom_range(0, 3));
          c1 = 2'($urandom_range(0, 3));
          c2 = 2'($urandom_range(0, 3));
          vb = 1'($urandom_range(0, 1));
        end
        send_item(op, stamp, c1, c2, vb);
        sent++;
      end
    end
  endtask

  task automatic test_sink_path();
    send_item(trac_pkg::OP_POLL, 32'd0, 2'd0, 2'd0, 1'b0);
    send_item(trac_pkg::OP_POLL, 32'd10, 2'd3, 2'd0, 1'b0);
    send_item(trac_pkg::OP_POLL, 32'd90, 2'd3, 2'd0, 1'b0);
    send_item(trac_pkg::OP_POLL, 32'd100, 2'd3, 2'd0, 1'b1);
    send_item(trac_pkg::OP_POLL, 32'd300, 2'd3, 2'd0, 1'b1);
    send_item(trac_pkg::OP_SINK, 32'd301, 2'd3, 2'd0, 1'b1);
    send_item(trac_pkg::OP_SOURCE, 32'd302, 2'd3, 2'd0, 1'b1);
    // VBUS drop while active, judged against the last CC change
    send_item(trac_pkg::OP_POLL, 32'd310, 2'd3, 2'd0, 1'b0);
  endtask

  task automatic test_source_path();
    send_item(trac_pkg::OP_SOURCE, 32'd330, 2'd0, 2'd0, 1'b0);
    send_item(trac_pkg::OP_POLL, 32'd340, 2'd0, 2'd1, 1'b0);
    send_item(trac_pkg::OP_POLL, 32'd420, 2'd0, 2'd1, 1'b0);
    send_item(trac_pkg::OP_POLL, 32'd430, 2'd0, 2'd1, 1'b1);
    send_item(trac_pkg::OP_POLL, 32'd630, 2'd0, 2'd1, 1'b1);
    send_item(trac_pkg::OP_POLL, 32'd640, 2'd0, 2'd0, 1'b1);
    send_item(trac_pkg::OP_POLL, 32'd760, 2'd0, 2'd0, 1'b0);
  endtask

  task automatic test_role_exit();
    send_item(trac_pkg::OP_TOGGLE, 32'd770, 2'd0, 2'd0, 1'b1);
    send_item(trac_pkg::OP_SOURCE, 32'd800, 2'd0, 2'd0, 1'b1);
    send_item(trac_pkg::OP_POLL, 32'd920, 2'd0, 2'd0, 1'b1);
    send_item(trac_pkg::OP_SINK, 32'd930, 2'd0, 2'd0, 1'b0);
    send_item(trac_pkg::OP_POLL, 32'd1080, 2'd0, 2'd0, 1'b0);
  endtask

  task automatic test_timestamp_wrap();
    send_item(trac_pkg::OP_POLL, 32'hFFFF_FFF0, 2'd1, 2'd0, 1'b0);
    send_item(trac_pkg::OP_POLL, 32'h0000_0040, 2'd1, 2'd0, 1'b0);
    send_item(trac_pkg::OP_POLL, 32'hFFFF_FFFF, 2'd3, 2'd3, 1'b1);
  endtask

  task automatic test_default_delays();
    program_timing(trac_pkg::ATTACH_RESET, trac_pkg::DETACH_RESET, trac_pkg::START_RESET,
                   trac_pkg::DISCHARGE_RESET);
    run_sessions(400);
  endtask

  task automatic test_zero_delays();
    program_timing(16'd0, 16'd0, 16'd0, 16'd0);
    run_sessions(350);
  endtask

  task automatic test_max_delays();
    program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_sessions(300);
  endtask

  task automatic test_short_delays();
    program_timing(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                   16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)));
    run_sessions(400);
  endtask

  task automatic test_mixed_delays();
    program_timing(pick_delay(), pick_delay(), pick_delay(), pick_delay());
    run_sessions(450);
  endtask

  initial begin
    reset_shadow();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_sink_path();
    test_source_path();
    test_role_exit();
    test_timestamp_wrap();
    test_default_delays();
    test_zero_delays();
    test_max_delays();
    test_short_delays();
    test_mixed_delays();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
